>>> src/snq_pkg.sv
`default_nettype none
package snq_pkg;

  localparam int NoteMax    = 127;
  localparam int NoteCount  = NoteMax + 1;
  localparam int PcCount    = 12;
  localparam int SearchSpan = 6;

  localparam int NoteW  = 7;
  localparam int CountW = 8;
  localparam int PcW    = 4;
  localparam int SpanW  = 3;
  localparam int SnapW  = 9;
  localparam int OffsW  = 8;
  localparam int RootW  = 4;
  localparam int KindW  = 3;
  localparam int IndexW = 4;
  localparam int DataW  = 4;

  localparam logic [IndexW-1:0] RegRoot = 4'd0;
  localparam logic [IndexW-1:0] RegKind = 4'd1;

  localparam logic [RootW-1:0] RootMax = 4'd11;
  localparam logic [KindW-1:0] KindMax = 3'd6;

  typedef logic [PcCount-1:0] pc_mask_t;

  // Pitch classes of each scale, built on a root of C.
  localparam pc_mask_t ScaleMasks [7] = '{
    12'h AB5,  // major
    12'h 5AD,  // natural minor
    12'h 6AD,  // dorian
    12'h 6B5,  // mixolydian
    12'h 295,  // major pentatonic
    12'h 555,  // whole tone
    12'h FFF   // chromatic
  };

  localparam pc_mask_t ResetMask = 12'h AB5;

  typedef struct packed {
    logic               done;
    logic [CountW-1:0]  count;
    logic [NoteW-1:0]   best;
    logic [PcW-1:0]     note_pc;
  } scan_stat_t;

  // Rotates the base scale up by the root; both inputs are already saturated.
  function automatic pc_mask_t build_mask(input logic [RootW-1:0] root,
                                          input logic [KindW-1:0] kind);
    pc_mask_t               base;
    logic [2*PcCount-1:0]   wide;
    base = ScaleMasks[kind];
    wide = {base, base} << root;
    return wide[2*PcCount-1:PcCount];
  endfunction

endpackage
`default_nettype wire

>>> src/scale_note_quantizer.sv
`default_nettype none
// Channel   Handshake              Payload
// input     in_valid / in_stall    note, degree_offset
// output    out_valid / out_stall  snapped_note, moved_note
// config    cfg_we                 cfg_index, cfg_data
//
// A result is registered once its accepted input beat has been through the walk
// over all 128 candidate notes, one per cycle, through a single in-scale test and
// distance compare; StLoad then loads the pitch-class search, StSnap runs it, and
// the list lookup in the note RAM and the output load follow. The input is free
// again from the edge that loads the result. Reset is synchronous, restores C
// major and holds the input stalled. The input is stalled for the whole of an
// item, but a finished result waits in the output register, so a new beat is
// taken while the previous result is still stalled downstream; a second result
// then waits until the first has left.
module scale_note_quantizer (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [snq_pkg::NoteW-1:0]          note,
  input  wire  signed [snq_pkg::OffsW-1:0]   degree_offset,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [snq_pkg::SnapW-1:0]   snapped_note,
  output logic [snq_pkg::NoteW-1:0]          moved_note,
  input  wire                                cfg_we,
  input  wire  [snq_pkg::IndexW-1:0]         cfg_index,
  input  wire  [snq_pkg::DataW-1:0]          cfg_data
);
  import snq_pkg::*;

  // Sequencer states.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StWalk  = 3'd1;
  localparam logic [2:0] StLoad  = 3'd2;
  localparam logic [2:0] StSnap  = 3'd3;
  localparam logic [2:0] StClamp = 3'd4;
  localparam logic [2:0] StRead  = 3'd5;
  localparam logic [2:0] StFin   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // Configuration. The mask is rebuilt in the same cycle as any register write.
  logic [RootW-1:0] root;
  logic [KindW-1:0] kind;
  logic [RootW-1:0] root_next;
  logic [KindW-1:0] kind_next;
  pc_mask_t         mask;

  always_comb begin
    root_next = root;
    kind_next = kind;
    if (cfg_we) begin
      case (cfg_index)
        RegRoot: root_next = (cfg_data > RootMax) ? RootMax : cfg_data;
        RegKind: kind_next = (cfg_data[KindW-1:0] > KindMax) ? KindMax
                                                             : cfg_data[KindW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
      kind <= '0;
      mask <= ResetMask;
    end else if (cfg_we) begin
      root <= root_next;
      kind <= kind_next;
      mask <= build_mask(root_next, kind_next);
    end
  end

  // Captured item.
  logic [NoteW-1:0]        note_q;
  logic signed [OffsW-1:0] offs_q;
  logic signed [SnapW-1:0] snap_q;
  logic                    in_take;

  assign in_stall = rst || (state != StIdle);
  assign in_take  = in_valid && !in_stall;

  // The walk: every note 0..127 is tested, in-scale notes go into the RAM in
  // ascending order, and the index of the nearest one is kept.
  scan_stat_t       scan;
  logic             ram_we;
  logic [NoteW-1:0] ram_waddr;
  logic [NoteW-1:0] ram_wdata;

  snq_scan u_scan (
    .clk     (clk),
    .start   (in_take),
    .run     (state == StWalk),
    .note    (note_q),
    .mask    (mask),
    .stat    (scan),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata)
  );

  // Nearest in-scale pitch class, searched outward from the note's own class.
  logic                    snap_done;
  logic signed [SnapW-1:0] snap_val;

  snq_snap u_snap (
    .clk     (clk),
    .start   (state == StLoad),
    .run     (state == StSnap),
    .note    (note_q),
    .note_pc (scan.note_pc),
    .mask    (mask),
    .done    (snap_done),
    .snapped (snap_val)
  );

  // Move through the list by the offset and clamp the index to the list.
  localparam int TgtW = OffsW + 2;

  logic signed [TgtW-1:0] tgt;
  logic signed [TgtW-1:0] last_idx;
  logic [NoteW-1:0]       rd_addr;
  logic                   list_empty;

  always_comb begin
    tgt        = $signed({{(TgtW-NoteW){1'b0}}, scan.best})
               + $signed({{(TgtW-OffsW){offs_q[OffsW-1]}}, offs_q});
    last_idx   = $signed({{(TgtW-CountW){1'b0}}, scan.count}) - TgtW'(1);
    list_empty = (scan.count == '0);
    if (tgt < 0) begin
      rd_addr = '0;
    end else if (tgt > last_idx) begin
      rd_addr = last_idx[NoteW-1:0];
    end else begin
      rd_addr = tgt[NoteW-1:0];
    end
  end

  logic [NoteW-1:0] ram_rdata;

  snq_ram #(
    .Width (NoteW),
    .Depth (NoteCount)
  ) u_list (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (state == StClamp),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      StIdle:  if (in_take) state_next = StWalk;
      StWalk:  if (scan.done) state_next = StLoad;
      StLoad:  state_next = StSnap;
      StSnap:  if (snap_done) state_next = StClamp;
      StClamp: state_next = StRead;
      StRead:  state_next = StFin;
      StFin:   if (out_free) state_next = StIdle;
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == StFin && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      note_q <= note;
      offs_q <= degree_offset;
    end
    if (snap_done) begin
      snap_q <= snap_val;
    end
    if (state == StFin && out_free) begin
      snapped_note <= snap_q;
      moved_note   <= list_empty ? note_q : ram_rdata;
    end
  end

endmodule
`default_nettype wire

>>> src/snq_ram.sv
`default_nettype none
module snq_ram #(
  parameter int Width = 8,
  parameter int Depth = 128
) (
  input  wire                      clk,
  input  wire                      wr_en,
  input  wire  [$clog2(Depth)-1:0] wr_addr,
  input  wire  [Width-1:0]         wr_data,
  input  wire                      rd_en,
  input  wire  [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> src/snq_scan.sv
`default_nettype none
module snq_scan (
  input  wire                              clk,
  input  wire                              start,
  input  wire                              run,
  input  wire  [snq_pkg::NoteW-1:0]        note,
  input  wire  snq_pkg::pc_mask_t          mask,
  output snq_pkg::scan_stat_t              stat,
  output logic                             wr_en,
  output logic [snq_pkg::NoteW-1:0]        wr_addr,
  output logic [snq_pkg::NoteW-1:0]        wr_data
);
  import snq_pkg::*;

  logic [NoteW-1:0]  n;
  logic [PcW-1:0]    pc;
  logic [CountW-1:0] count;
  logic [NoteW-1:0]  best;
  logic [NoteW-1:0]  bestd;
  logic              have_best;
  logic [PcW-1:0]    note_pc;

  logic             hit;
  logic [NoteW-1:0] delta;
  logic             closer;

  // One candidate note per cycle: in-scale test, distance and compare.
  always_comb begin
    hit     = mask[pc];
    delta   = (n >= note) ? (n - note) : (note - n);
    closer  = !have_best || (delta < bestd);
    wr_en   = run && hit;
    wr_addr = count[NoteW-1:0];
    wr_data = n;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n         <= '0;
      pc        <= '0;
      count     <= '0;
      have_best <= 1'b0;
    end else if (run) begin
      if (hit) begin
        count <= count + CountW'(1);
        if (closer) begin
          best      <= count[NoteW-1:0];
          bestd     <= delta;
          have_best <= 1'b1;
        end
      end
      if (n == note) begin
        note_pc <= pc;
      end
      pc <= (pc == PcW'(PcCount - 1)) ? '0 : pc + PcW'(1);
      n  <= n + NoteW'(1);
    end
  end

  assign stat.done    = run && (n == NoteW'(NoteMax));
  assign stat.count   = count;
  assign stat.best    = best;
  assign stat.note_pc = note_pc;

endmodule
`default_nettype wire

>>> src/snq_snap.sv
`default_nettype none
module snq_snap (
  input  wire                              clk,
  input  wire                              start,
  input  wire                              run,
  input  wire  [snq_pkg::NoteW-1:0]        note,
  input  wire  [snq_pkg::PcW-1:0]          note_pc,
  input  wire  snq_pkg::pc_mask_t          mask,
  output logic                             done,
  output logic signed [snq_pkg::SnapW-1:0] snapped
);
  import snq_pkg::*;

  logic [PcW-1:0]   pc_dn;
  logic [PcW-1:0]   pc_up;
  logic [SpanW-1:0] k;

  logic             hit_dn;
  logic             hit_up;
  logic [SnapW-1:0] note_w;
  logic [SnapW-1:0] k_w;

  // Step outward one pitch class a cycle, the lower side tried first.
  always_comb begin
    hit_dn = mask[pc_dn];
    hit_up = mask[pc_up];
    note_w = {{(SnapW-NoteW){1'b0}}, note};
    k_w    = {{(SnapW-SpanW){1'b0}}, k};
    done   = run && (hit_dn || hit_up || (k == SpanW'(SearchSpan)));
    if (hit_dn) begin
      snapped = note_w - k_w;
    end else if (hit_up) begin
      snapped = note_w + k_w;
    end else begin
      snapped = note_w;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      pc_dn <= note_pc;
      pc_up <= note_pc;
      k     <= '0;
    end else if (run) begin
      pc_dn <= (pc_dn == '0) ? PcW'(PcCount - 1) : pc_dn - PcW'(1);
      pc_up <= (pc_up == PcW'(PcCount - 1)) ? '0 : pc_up + PcW'(1);
      k     <= k + SpanW'(1);
    end
  end

endmodule
`default_nettype wire

>>> verif/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The run is stopped if this many cycles go by with no beat and no write.
  localparam int WatchLimit   = 2000;
  // Quiet cycles after the last result, to catch a stray beat.
  localparam int DrainPause   = 200;
  localparam int RandomItems  = 1100;
  localparam int PrintedFaults = 30;

  // Scale selections, in the order of the scale_kind register.
  typedef enum logic [3:0] {
    ScMajor, ScMinor, ScDorian, ScMixolydian, ScPentatonic, ScWholeTone, ScChromatic
  } scale_e;

  // Register values above the legal range. They should saturate to the top entry.
  localparam logic [3:0] RootOverflow = 4'd15;
  localparam logic [3:0] KindOverflow = 4'd7;

  typedef struct {
    int                note_in;
    int                offs_in;
    logic signed [8:0] snap;
    logic [6:0]        moved;
  } quantised_t;

  // The block takes one beat per note and gives one result beat for it, which is
  // held back while the output is stalled. This tracker keeps its own copy of the
  // root and scale registers and the pitch-class set built from them. For every
  // input beat that the block accepts, it works out the snapped note and the moved
  // note. Each result beat is then compared with the oldest of these.
  class scale_tracker;
    logic [11:0]  pc_set;
    int           root_pc;
    int           kind_sel;
    quantised_t   awaited[$];
    int           mismatches;
    int           beats;
    int           results;
    int           outside;

    function new();
      root_pc    = 0;
      kind_sel   = ScMajor;
      mismatches = 0;
      beats      = 0;
      results    = 0;
      outside    = 0;
      rebuild();
    endfunction

    function logic [11:0] scale_base(int kind);
      case (kind)
        ScMajor:      return 12'hAB5;  // 0 2 4 5 7 9 11
        ScMinor:      return 12'h5AD;  // 0 2 3 5 7 8 10
        ScDorian:     return 12'h6AD;  // 0 2 3 5 7 9 10
        ScMixolydian: return 12'h6B5;  // 0 2 4 5 7 9 10
        ScPentatonic: return 12'h295;  // 0 2 4 7 9
        ScWholeTone:  return 12'h555;  // 0 2 4 6 8 10
        default:      return 12'hFFF;
      endcase
    endfunction

    function void rebuild();
      logic [11:0] base;
      base   = scale_base(kind_sel);
      pc_set = '0;
      for (int p = 0; p < 12; p++)
        if (base[p]) pc_set[(p + root_pc) % 12] = 1'b1;
    endfunction

    function void reg_write(logic [3:0] idx, logic [3:0] val);
      if (idx == snq_pkg::RegRoot) begin
        root_pc = (val > snq_pkg::RootMax) ? snq_pkg::RootMax : val;
        rebuild();
      end else if (idx == snq_pkg::RegKind) begin
        kind_sel = (val[2:0] > snq_pkg::KindMax) ? snq_pkg::KindMax : val[2:0];
        rebuild();
      end
    endfunction

    function void quantise(int n, int off, output int snap, output int moved);
      int pc;
      int cnt;
      int best;
      int bestd;
      int d;
      int tgt;
      int ladder[128];
      snap = n;
      pc   = n % 12;
      if (!pc_set[pc]) begin
        for (int k = 1; k <= 6; k++) begin
          if (pc_set[(pc - k + 12) % 12]) begin
            snap = n - k;
            break;
          end
          if (pc_set[(pc + k) % 12]) begin
            snap = n + k;
            break;
          end
        end
      end
      cnt = 0;
      for (int m = 0; m < 128; m++) begin
        if (pc_set[m % 12]) begin
          ladder[cnt] = m;
          cnt++;
        end
      end
      moved = n;
      if (cnt > 0) begin
        best  = 0;
        bestd = (ladder[0] > n) ? ladder[0] - n : n - ladder[0];
        for (int k = 1; k < cnt; k++) begin
          d = (ladder[k] > n) ? ladder[k] - n : n - ladder[k];
          if (d < bestd) begin
            bestd = d;
            best  = k;
          end
        end
        tgt = best + off;
        if (tgt < 0) tgt = 0;
        if (tgt > cnt - 1) tgt = cnt - 1;
        moved = ladder[tgt];
      end
    endfunction

    function void note_beat(logic [6:0] n, logic signed [7:0] off);
      quantised_t want;
      int         snap;
      int         moved;
      want.note_in = n;
      want.offs_in = off;
      quantise(want.note_in, want.offs_in, snap, moved);
      want.snap  = snap;
      want.moved = moved;
      if (snap < 0 || snap > 127) outside++;
      beats++;
      awaited.insert(awaited.size(), want);
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= PrintedFaults) $display("mismatch: %s", msg);
    endtask

    task check_result(logic signed [8:0] snap, logic [6:0] moved);
      quantised_t want;
      results++;
      if (awaited.size() == 0) begin
        report($sformatf("result beat with nothing awaited: snapped %0d moved %0d",
                         snap, moved));
        return;
      end
      want = awaited.pop_front();
      if (snap !== want.snap)
        report($sformatf("note %0d offset %0d: snapped_note %0d, wanted %0d",
                         want.note_in, want.offs_in, snap, want.snap));
      if (moved !== want.moved)
        report($sformatf("note %0d offset %0d: moved_note %0d, wanted %0d",
                         want.note_in, want.offs_in, moved, want.moved));
    endtask
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic [snq_pkg::NoteW-1:0]           note = '0;
  logic signed [snq_pkg::OffsW-1:0]    degree_offset = '0;
  logic                                out_stall = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [snq_pkg::IndexW-1:0]          cfg_index = '0;
  logic [snq_pkg::DataW-1:0]           cfg_data = '0;
  wire                                 in_stall;
  wire                                 out_valid;
  wire signed [snq_pkg::SnapW-1:0]     snapped_note;
  wire [snq_pkg::NoteW-1:0]            moved_note;

  scale_tracker board;
  bit           in_idle = 1'b0;
  bit           out_idle = 1'b0;
  int           stall_left = 0;
  int           quiet = 0;
  int           settings = 0;

  scale_note_quantizer dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .note          (note),
    .degree_offset (degree_offset),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .snapped_note  (snapped_note),
    .moved_note    (moved_note),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // Mostly no gap, now and then a few cycles, and once in a while a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 48);
  endfunction

  // Most offsets stay within an octave or so of steps, so that the move lands
  // inside the ladder; the rest cover the whole signed range and hit the clamps.
  function automatic logic [7:0] pick_offset();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 16) - 8);
    return 8'($urandom_range(0, 255));
  endfunction

  // The receiver stalls in bursts, so that a stall can meet a result beat at
  // any point; with out_idle clear it starts no new burst.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (out_idle) stall_left <= pick_gap();
    end
  end

  // Both channels are sampled here, with the values held just before the edge.
  // A result is checked before the new note is noted; the new note always
  // lands at the back of the queue, so the order does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) board.check_result(snapped_note, moved_note);
      if (in_valid && !in_stall) board.note_beat(note, degree_offset);
    end
  end

  // The watchdog counts cycles with no beat on either channel and no write.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    wait (quiet >= WatchLimit);
    $display("timeout after %0d quiet cycles, %0d results still awaited",
             quiet, board.awaited.size());
    $display("tb: FAIL");
    $finish;
  end

  // One register write per edge. The caller lowers cfg_we after the last one,
  // so that cfg_we is never dropped and raised again in the same step.
  task automatic reg_write(logic [3:0] idx, logic [3:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.reg_write(idx, val);
  endtask

  // Writes both registers and, if asked, one index that the block must ignore.
  task automatic apply_scale(logic [3:0] root_v, logic [3:0] kind_v, bit stray);
    reg_write(snq_pkg::RegRoot, root_v);
    reg_write(snq_pkg::RegKind, kind_v);
    if (stray)
      reg_write(4'($urandom_range(snq_pkg::RegKind + 1, 15)), 4'($urandom_range(0, 15)));
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Drives one note beat and returns at the edge where it is taken. The valid
  // is left high, so that a following beat can go out without a gap.
  task automatic send_note(logic [6:0] n, logic [7:0] off);
    int gap;
    gap = in_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    note          <= n;
    degree_offset <= off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Waits until every awaited result has come back. The queue is read at the
  // falling edge, once the monitor has finished with the rising one.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (board.awaited.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int batch;
    int sent;
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset leaves C major. The extremes of both fields, a C sharp that lies
    // halfway between C and D and must go down, and offsets that run off
    // either end of the ladder.
    send_note(7'd0, 8'd0);
    send_note(7'd127, 8'd0);
    send_note(7'd61, 8'd0);
    send_note(7'd64, 8'h80);
    send_note(7'd64, 8'h7F);
    send_note(7'd0, 8'hFF);
    send_note(7'd127, 8'd1);

    // D pentatonic lacks C, so note 0 snaps down below zero.
    wait_drained();
    apply_scale(4'd2, ScPentatonic, 1'b0);
    send_note(7'd0, 8'd0);
    send_note(7'd127, 8'd0);

    // A flat pentatonic lacks F sharp and G, so note 127 snaps up past the top.
    wait_drained();
    apply_scale(4'd8, ScPentatonic, 1'b0);
    send_note(7'd127, 8'd0);
    send_note(7'd0, 8'h80);

    // Both registers out of range: the root saturates to B and the scale to
    // chromatic. A write to an unused index goes along with them.
    wait_drained();
    apply_scale(RootOverflow, KindOverflow, 1'b1);
    send_note(7'd5, 8'd3);
    send_note(7'd127, 8'h7F);

    // A whole-tone scale on E flat puts C halfway between two scale notes.
    wait_drained();
    apply_scale(4'd3, ScWholeTone, 1'b0);
    send_note(7'd60, 8'd0);
    send_note(7'd61, 8'hFD);

    // Kind data with its top bit set: that bit is dropped, leaving minor.
    wait_drained();
    apply_scale(4'd11, 4'd9, 1'b0);
    send_note(7'd70, 8'd2);
    send_note(7'd1, 8'hF8);

    wait_drained();
    apply_scale(4'd5, ScDorian, 1'b0);
    send_note(7'd66, 8'd4);

    wait_drained();
    apply_scale(4'd7, ScMixolydian, 1'b0);
    send_note(7'd100, 8'hFC);

    // Random part: a fresh scale setting for each batch, with idling on each
    // side switched on for most batches and off for the rest.
    sent = 0;
    while (sent < RandomItems) begin
      wait_drained();
      apply_scale(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  $urandom_range(0, 2) == 0);
      in_idle  = $urandom_range(0, 3) != 0;
      out_idle = $urandom_range(0, 3) != 0;
      batch    = $urandom_range(15, 60);
      for (int i = 0; i < batch; i++) begin
        send_note(7'($urandom_range(0, 127)), pick_offset());
        sent++;
      end
    end

    wait_drained();
    repeat (DrainPause) @(posedge clk);

    $display("covered %0d notes over %0d scale settings, %0d snapped outside 0..127",
             board.beats, settings, board.outside);
    $display("%0d result beats checked, %0d mismatches", board.results, board.mismatches);
    if (board.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
